// ===== design/utf8_token_boundary_parser_core_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the utf8 token boundary parser
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef UTF8_TOKEN_BOUNDARY_PARSER_CORE_ASSERT_SVH
`define UTF8_TOKEN_BOUNDARY_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define UTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/utp_pkg.sv =====
// ---------------------------------------------------------------------------
// utp_pkg
// shared types and constants of the utf8 token boundary parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utp_pkg;

  // position counter width default and result field width
  localparam int POSITION_WIDTH_DEF = 32;
  localparam int BYTE_POS_W         = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UTF8_MODE  = 2'd0,
    CFG_SPLIT_MODE = 2'd1
  } cfg_idx_t;

  // token split modes
  typedef enum logic [1:0] {
    SPLIT_SYMBOL = 2'd0,
    SPLIT_WORD   = 2'd1,
    SPLIT_LINE   = 2'd2,
    SPLIT_UNUSED = 2'd3
  } split_mode_t;

  // per-byte error codes
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_LEAD_LONG = 3'd1,
    ERR_BAD_CONT  = 3'd2,
    ERR_TRUNC     = 3'd3,
    ERR_ABORT     = 3'd4
  } err_t;

  // byte classes
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MATCH = 8'h80;
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] SPACE      = 8'h20;
  localparam logic [7:0] WS_LO      = 8'h09;
  localparam logic [7:0] WS_HI      = 8'h0D;

  localparam logic       UTF8_MODE_RST  = 1'b1;

endpackage

`default_nettype wire

// ===== design/utf8_token_boundary_parser_core.sv =====
// ---------------------------------------------------------------------------
// utf8_token_boundary_parser_core
// per-byte utf8 symbol and token boundary marking with sticky error report
// ---------------------------------------------------------------------------
// One word in, one word out. A byte is taken every cycle as long as the
// result side keeps up; once accepted it passes the input register, then the
// result register, which presents its result word until taken. The rate is
// set by the parse state loop (pending continuation count, splitter flag,
// error flag and position counter), which is updated once per byte as it
// leaves the input register. Stall on the result side propagates
// to in_stall in the same cycle. Configuration writes are always ready and
// take effect on the next byte processed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_token_boundary_parser_core #(
  parameter int POSITION_WIDTH = utp_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [utp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [utp_pkg::CFG_DATA_W-1:0] cfg_data,
  // byte input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_byte_value,
  input  wire logic                           in_last_byte,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [utp_pkg::BYTE_POS_W-1:0]      out_byte_position,
  output logic                                out_symbol_start,
  output logic                                out_token_start,
  output logic [2:0]                          out_error_code
);

  import utp_pkg::*;

  `include "utf8_token_boundary_parser_core_assert.svh"

  localparam int EXT_W = (POSITION_WIDTH > BYTE_POS_W) ? POSITION_WIDTH : BYTE_POS_W;

  // configuration registers
  logic        utf8_mode_r;
  split_mode_t split_mode_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parse state
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [1:0]                pend_r, pend_nxt;
  logic                      prev_split_r, prev_split_nxt;
  logic                      failed_r, failed_nxt;

  // result register
  logic                  out_valid_r;
  logic [BYTE_POS_W-1:0] out_pos_r;
  logic                  out_sym_r, out_tok_r;
  err_t                  out_err_r;

  // per-byte results
  logic       res_sym, res_tok;
  err_t       res_err;
  logic       word_like, is_split, pos_zero;
  logic [1:0] lead_pend;
  logic       lead_long;
  logic [EXT_W-1:0] pos_ext;

  // handshake
  logic out_free, s1_adv, in_acc;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_mode_r  <= UTF8_MODE_RST;
      split_mode_r <= SPLIT_SYMBOL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UTF8_MODE:  utf8_mode_r  <= cfg_data[0];
        CFG_SPLIT_MODE: split_mode_r <= split_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
  end

  // byte classification
  always_comb begin
    word_like = (split_mode_r == SPLIT_WORD) || (split_mode_r == SPLIT_LINE);
    case (split_mode_r)
      SPLIT_WORD: is_split = (s1_byte_r inside {[WS_LO:WS_HI], SPACE});
      SPLIT_LINE: is_split = (s1_byte_r == NEWLINE);
      default:    is_split = 1'b0;
    endcase
    pos_zero = (pos_r == '0);
    // sequence length from the ones below bit 6 of the lead byte
    lead_long = 1'b0;
    if (!s1_byte_r[5]) begin
      lead_pend = 2'd1;
    end else if (!s1_byte_r[4]) begin
      lead_pend = 2'd2;
    end else if (!s1_byte_r[3]) begin
      lead_pend = 2'd3;
    end else begin
      lead_pend = 2'd0;
      lead_long = 1'b1;
    end
  end

  // parse step
  always_comb begin
    res_sym        = 1'b0;
    res_tok        = 1'b0;
    res_err        = ERR_OK;
    pend_nxt       = pend_r;
    prev_split_nxt = prev_split_r;
    failed_nxt     = failed_r;
    if (failed_r) begin
      res_err = ERR_ABORT;
    end else if (pend_r != 2'd0) begin
      // continuation byte expected
      if ((s1_byte_r & CONT_MASK) != CONT_MATCH) begin
        res_err    = ERR_BAD_CONT;
        failed_nxt = 1'b1;
      end else begin
        pend_nxt = pend_r - 2'd1;
        if (s1_last_r && (pend_r != 2'd1)) begin
          res_err    = ERR_TRUNC;
          failed_nxt = 1'b1;
        end
      end
    end else if (utf8_mode_r && s1_byte_r[7]) begin
      // multibyte lead
      if (lead_long) begin
        res_err    = ERR_LEAD_LONG;
        failed_nxt = 1'b1;
      end else begin
        pend_nxt = lead_pend;
        if (s1_last_r) begin
          res_err    = ERR_TRUNC;
          failed_nxt = 1'b1;
        end else begin
          res_sym        = 1'b1;
          res_tok        = word_like ? (pos_zero || prev_split_r) : 1'b1;
          prev_split_nxt = 1'b0;
        end
      end
    end else begin
      // single-byte symbol
      res_sym        = 1'b1;
      res_tok        = word_like ? (pos_zero || is_split || prev_split_r) : 1'b1;
      prev_split_nxt = is_split;
    end
    // end of data set clears the parse state
    if (s1_last_r) begin
      pos_nxt        = '0;
      pend_nxt       = 2'd0;
      prev_split_nxt = 1'b0;
      failed_nxt     = 1'b0;
    end else begin
      pos_nxt = pos_r + POSITION_WIDTH'(1);
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      pend_r       <= 2'd0;
      prev_split_r <= 1'b0;
      failed_r     <= 1'b0;
    end else if (s1_adv) begin
      pos_r        <= pos_nxt;
      pend_r       <= pend_nxt;
      prev_split_r <= prev_split_nxt;
      failed_r     <= failed_nxt;
    end
  end

  // result register
  assign pos_ext = EXT_W'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pos_r <= pos_ext[BYTE_POS_W-1:0];
      out_sym_r <= res_sym;
      out_tok_r <= res_tok;
      out_err_r <= res_err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_position = out_pos_r;
  assign out_symbol_start  = out_sym_r;
  assign out_token_start   = out_tok_r;
  assign out_error_code    = out_err_r;

  // checks
  `UTP_ASSERT_NOW(a_err_no_start, out_valid_r && (out_err_r != ERR_OK), !out_sym_r && !out_tok_r, "error word marks a boundary")
  `UTP_ASSERT_NOW(a_tok_needs_sym, out_valid_r && out_tok_r, out_sym_r, "token start without symbol start")
  `UTP_ASSERT_NEXT(a_err_sticks, s1_adv && (res_err != ERR_OK) && !s1_last_r, failed_r, "error not kept")
  `UTP_ASSERT_NEXT(a_last_clears, s1_adv && s1_last_r, (pos_r == '0) && (pend_r == 2'd0) && !failed_r, "state not cleared at end of data")
  `UTP_ASSERT_NOW(a_stall_src, in_stall, s1_valid_r && out_valid_r && out_stall, "input stalled with room free")

endmodule

`default_nettype wire

// ===== verif/tb_utf8_token_boundary_parser_core.sv =====
// ---------------------------------------------------------------------------
// tb_utf8_token_boundary_parser_core
// self-checking bench for the utf8 symbol and token boundary parser
// ---------------------------------------------------------------------------
// A short table of directed words (error codes, truncation, stray
// continuation, mode change in the middle of a symbol, every split mode) is
// walked first. Random text follows in several phases. Each phase has its own
// mode setting and idling pattern. The text is mostly well-formed utf8 with
// words, spaces and newlines, mixed with broken sequences and raw noise.
// Results are checked against typed rows or the in-bench boundary predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_token_boundary_parser_core;
  import utp_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 230;

  // expected result word of one byte
  typedef struct packed {
    logic [BYTE_POS_W-1:0] pos;
    logic                  sym;
    logic                  tok;
    err_t                  err;
  } boundary_t;

  // directed table row: a mode write or one text byte
  typedef struct {
    bit          is_cfg;
    logic        utf8;
    split_mode_t split;
    logic [7:0]  b;
    logic        last;
    bit          typed;
    boundary_t   want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte_value = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_POS_W-1:0] out_byte_position;
  logic                  out_symbol_start;
  logic                  out_token_start;
  logic [2:0]            out_error_code;

  // predictor state and its copy of the mode registers
  logic [BYTE_POS_W-1:0] pos_count = '0;
  logic [1:0]            cont_left = '0;
  logic                  after_split = 1'b0;
  logic                  aborted = 1'b0;
  logic                  utf8_on = UTF8_MODE_RST;
  split_mode_t           split_sel = SPLIT_SYMBOL;

  boundary_t boundary_q[$];
  dir_row_t  dir_rows[$];
  logic [8:0] text_q[$];   // {last, byte}
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  logic        phase_utf8[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  split_mode_t phase_split[PHASES] = '{SPLIT_SYMBOL, SPLIT_WORD, SPLIT_WORD, SPLIT_LINE,
                                       SPLIT_LINE, SPLIT_UNUSED, SPLIT_SYMBOL, SPLIT_WORD};

  utf8_token_boundary_parser_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_position (out_byte_position),
    .out_symbol_start  (out_symbol_start),
    .out_token_start   (out_token_start),
    .out_error_code    (out_error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // boundary predictor: advances the parse state by one byte
  function automatic boundary_t parse_byte(input logic [7:0] b, input logic last);
    boundary_t r;
    logic      word_like;
    logic      split;
    r = '{pos: pos_count, sym: 1'b0, tok: 1'b0, err: ERR_OK};
    word_like = (split_sel == SPLIT_WORD) || (split_sel == SPLIT_LINE);
    if (aborted) begin
      r.err = ERR_ABORT;
    end else if (cont_left != 2'd0) begin
      // continuation bytes are checked whatever the mode now says
      if ((b & CONT_MASK) != CONT_MATCH) begin
        r.err = ERR_BAD_CONT;
        aborted = 1'b1;
      end else begin
        cont_left = cont_left - 2'd1;
        if (last && cont_left != 2'd0) begin
          r.err = ERR_TRUNC;
          aborted = 1'b1;
        end
      end
    end else if (utf8_on && b[7]) begin
      // length from the run of ones starting at bit 5
      if (b[5:3] == 3'b111) begin
        r.err = ERR_LEAD_LONG;
        aborted = 1'b1;
      end else begin
        cont_left = !b[5] ? 2'd1 : (!b[4] ? 2'd2 : 2'd3);
        if (last) begin
          r.err = ERR_TRUNC;
          aborted = 1'b1;
        end else begin
          r.sym = 1'b1;
          r.tok = word_like ? (pos_count == '0 || after_split) : 1'b1;
          after_split = 1'b0;
        end
      end
    end else begin
      if (split_sel == SPLIT_WORD)
        split = (b >= WS_LO && b <= WS_HI) || b == SPACE;
      else if (split_sel == SPLIT_LINE)
        split = (b == NEWLINE);
      else
        split = 1'b0;
      r.sym = 1'b1;
      r.tok = word_like ? (pos_count == '0 || split || after_split) : 1'b1;
      after_split = split;
    end
    // end of data set clears everything
    if (last) begin
      pos_count   = '0;
      cont_left   = 2'd0;
      after_split = 1'b0;
      aborted     = 1'b0;
    end else begin
      pos_count = pos_count + 1'b1;
    end
    return r;
  endfunction

  // table rows
  function automatic void row_item(input logic [7:0] b, input logic last);
    dir_row_t r;
    r = '{is_cfg: 1'b0, utf8: 1'b0, split: SPLIT_SYMBOL, b: b, last: last,
          typed: 1'b0, want: '0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_typed(input logic [7:0] b, input logic last,
                                    input logic [BYTE_POS_W-1:0] pos,
                                    input logic sym, input logic tok, input err_t err);
    dir_row_t r;
    r = '{is_cfg: 1'b0, utf8: 1'b0, split: SPLIT_SYMBOL, b: b, last: last,
          typed: 1'b1, want: '{pos: pos, sym: sym, tok: tok, err: err}};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_cfg(input logic utf8, input split_mode_t split);
    dir_row_t r;
    r = '{is_cfg: 1'b1, utf8: utf8, split: split, b: '0, last: 1'b0,
          typed: 1'b0, want: '0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // append one {last, byte} entry to the text
  function automatic void text_add(input logic [8:0] w);
    text_q.insert(text_q.size(), w);
  endfunction

  // one random symbol of text, sometimes broken or plain noise
  function automatic void add_symbol();
    int sel;
    int len;
    int ncont;
    int k;
    logic [7:0] lead;
    sel = $urandom_range(0, 99);
    if (sel < 28) begin
      text_add({1'b0, 8'($urandom_range(8'h21, 8'h7E))});
    end else if (sel < 40) begin
      k = $urandom_range(0, 5);
      text_add({1'b0, (k == 5) ? SPACE : 8'(WS_LO + k)});
    end else if (sel < 48) begin
      text_add({1'b0, NEWLINE});
    end else if (sel < 80) begin
      len = $urandom_range(2, 4);
      if (len == 2)
        lead = 8'hC0 | 8'($urandom_range(0, 31));
      else if (len == 3)
        lead = 8'hE0 | 8'($urandom_range(0, 15));
      else
        lead = 8'hF0 | 8'($urandom_range(0, 7));
      // a few sequences lose their tail
      ncont = (sel >= 74) ? $urandom_range(0, len - 2) : len - 1;
      text_add({1'b0, lead});
      repeat (ncont) text_add({1'b0, CONT_MATCH | 8'($urandom_range(0, 63))});
    end else if (sel < 90) begin
      text_add({1'b0, 8'($urandom_range(0, 255))});
    end else begin
      text_add({1'b0, 8'($urandom_range(8'h80, 8'hFF))});
    end
  endfunction

  // send one byte word and record what it should produce
  task automatic put_byte(input logic [7:0] b, input logic last,
                          input bit typed, input boundary_t want);
    boundary_t r;
    int        gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    do @(posedge clk); while (in_stall);
    r = parse_byte(b, last);
    boundary_q.insert(boundary_q.size(), typed ? want : r);
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain();
    in_valid <= 1'b0;
    while (boundary_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write both mode registers once the block is idle
  task automatic set_modes(input logic utf8, input split_mode_t split);
    drain();
    cfg_write(CFG_UTF8_MODE, {1'b0, utf8});
    cfg_write(CFG_SPLIT_MODE, split);
    cfg_valid <= 1'b0;
    utf8_on   = utf8;
    split_sel = split;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    boundary_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (boundary_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: pos %0d sym %0d tok %0d err %0d",
                   out_byte_position, out_symbol_start, out_token_start, out_error_code);
      end else begin
        want = boundary_q.pop_front();
        if (out_byte_position !== want.pos || out_symbol_start !== want.sym ||
            out_token_start !== want.tok || out_error_code !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected pos %0d sym %0d tok %0d err %0d, got pos %0d sym %0d tok %0d err %0d",
                     want.pos, want.sym, want.tok, want.err, out_byte_position,
                     out_symbol_start, out_token_start, out_error_code);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int   p;
    int   nsym;
    int   phase_count;
    logic [8:0] w;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset modes: utf8 grouping, symbol tokens
    row_typed(8'h41, 1'b0, 0, 1'b1, 1'b1, ERR_OK);
    row_typed(8'hC3, 1'b0, 1, 1'b1, 1'b1, ERR_OK);
    row_typed(8'hA9, 1'b0, 2, 1'b0, 1'b0, ERR_OK);
    row_typed(8'hF8, 1'b0, 3, 1'b0, 1'b0, ERR_LEAD_LONG);
    row_typed(8'h00, 1'b1, 4, 1'b0, 1'b0, ERR_ABORT);
    // lead cut short by end of data
    row_typed(8'hE2, 1'b1, 0, 1'b0, 1'b0, ERR_TRUNC);
    row_typed(8'hF0, 1'b0, 0, 1'b1, 1'b1, ERR_OK);
    row_item(8'h9F, 1'b0);
    row_typed(8'h98, 1'b1, 2, 1'b0, 1'b0, ERR_TRUNC);
    // bad continuation on the last byte
    row_item(8'hC3, 1'b0);
    row_typed(8'h41, 1'b1, 1, 1'b0, 1'b0, ERR_BAD_CONT);
    // stray continuation taken as a two-byte lead
    row_item(8'h80, 1'b0);
    row_item(8'hBF, 1'b1);
    row_typed(8'hFF, 1'b1, 0, 1'b0, 1'b0, ERR_LEAD_LONG);
    // word split, ending in the middle of a three-byte symbol
    row_cfg(1'b1, SPLIT_WORD);
    row_item(8'h20, 1'b0);
    row_item(8'h61, 1'b0);
    row_item(8'h62, 1'b0);
    row_item(8'h0D, 1'b0);
    row_item(8'hE4, 1'b0);
    // byte mode while continuation bytes are still due
    row_cfg(1'b0, SPLIT_WORD);
    row_item(8'hB8, 1'b0);
    row_item(8'h8D, 1'b0);
    row_item(8'hC3, 1'b0);
    row_item(8'h09, 1'b1);
    row_cfg(1'b1, SPLIT_LINE);
    row_item(8'h0A, 1'b0);
    row_item(8'h20, 1'b1);
    // unused split mode acts as symbol tokens
    row_cfg(1'b1, SPLIT_UNUSED);
    row_item(8'h0A, 1'b1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        set_modes(dir_rows[i].utf8, dir_rows[i].split);
      else
        put_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end

    // random text, one mode setting and idling pattern per phase
    for (p = 0; p < PHASES; p++) begin
      set_modes(phase_utf8[p], phase_split[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      phase_count = 0;
      while (phase_count < PHASE_BYTES) begin
        nsym = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
        repeat (nsym) add_symbol();
        text_q[text_q.size() - 1][8] = 1'b1;
        while (text_q.size() != 0) begin
          w = text_q.pop_front();
          put_byte(w[7:0], w[8], 1'b0, '0);
          phase_count++;
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
